// ===== rtl/svpwm_pkg.sv =====
// shared types, constants and helpers for the space vector duty calculator
`default_nettype none

package svpwm_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SQRT3 = 4'd1;
    localparam int CFG_DATA_W = 16;

    localparam int PERIOD_W = 14;
    localparam int SQRT3_W  = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 14'd1800;
    localparam logic [SQRT3_W-1:0]  SQRT3_RST  = 16'd12470;

    // period scale t = 4 * timer period
    localparam int T_W = PERIOD_W + 2;

    // product, x/y/z and numerator widths
    localparam int PROD_W = 34;
    localparam int NUM_W  = PROD_W + 1;

    // divide by 131072, and by 2 * 131072 for the combined numerator
    localparam int DIV_SHIFT     = 17;
    localparam int NUM_DIV_SHIFT = DIV_SHIFT + 1;

    localparam int DUTY_W = 16;

    typedef logic [2:0] t_sector;
    localparam t_sector SEC_1 = 3'd1;
    localparam t_sector SEC_2 = 3'd2;
    localparam t_sector SEC_3 = 3'd3;
    localparam t_sector SEC_4 = 3'd4;
    localparam t_sector SEC_5 = 3'd5;
    localparam t_sector SEC_6 = 3'd6;

    typedef struct packed {
        logic signed [15:0] v_alpha;
        logic signed [15:0] v_beta;
    } t_cmd;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        t_sector           sector;
    } t_result;

    // signed halving, truncated toward zero
    function automatic logic signed [PROD_W-1:0] half_trunc(
        input logic signed [NUM_W-1:0] v
    );
        logic signed [NUM_W-1:0] biased;
        logic signed [NUM_W-1:0] shifted;
        biased  = v + NUM_W'(v[NUM_W-1]);
        shifted = biased >>> 1;
        return shifted[PROD_W-1:0];
    endfunction

    // signed shift divide truncated toward zero, low duty bits kept
    function automatic logic [DUTY_W-1:0] quot_trunc(
        input logic signed [NUM_W-1:0] v,
        input int unsigned             sh
    );
        logic signed [NUM_W-1:0] bias;
        logic signed [NUM_W-1:0] shifted;
        bias    = v[NUM_W-1] ? ((NUM_W'(1) <<< sh) - NUM_W'(1)) : '0;
        shifted = (v + bias) >>> sh;
        return shifted[DUTY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/svpwm_xyz.sv =====
// x, y, z forming and sector choice from the scaled alpha/beta products
`default_nettype none

module svpwm_xyz (
    input  wire logic signed [svpwm_pkg::PROD_W-1:0] i_ua,
    input  wire logic signed [svpwm_pkg::PROD_W-1:0] i_ub,
    output logic signed [svpwm_pkg::PROD_W-1:0]      o_x,
    output logic signed [svpwm_pkg::PROD_W-1:0]      o_y,
    output logic signed [svpwm_pkg::PROD_W-1:0]      o_z,
    output svpwm_pkg::t_sector                       o_sector
);

    logic signed [svpwm_pkg::NUM_W-1:0] sum;
    logic signed [svpwm_pkg::NUM_W-1:0] diff;

    always_comb begin
        sum  = svpwm_pkg::NUM_W'(i_ub) + svpwm_pkg::NUM_W'(i_ua);
        diff = svpwm_pkg::NUM_W'(i_ub) - svpwm_pkg::NUM_W'(i_ua);
        o_x  = i_ub;
        o_y  = svpwm_pkg::half_trunc(sum);
        o_z  = svpwm_pkg::half_trunc(diff);

        if (o_y[svpwm_pkg::PROD_W-1]) begin
            if (o_z[svpwm_pkg::PROD_W-1]) begin
                o_sector = svpwm_pkg::SEC_5;
            end else if (o_x <= 0) begin
                o_sector = svpwm_pkg::SEC_4;
            end else begin
                o_sector = svpwm_pkg::SEC_3;
            end
        end else begin
            if (!o_z[svpwm_pkg::PROD_W-1]) begin
                o_sector = svpwm_pkg::SEC_2;
            end else if (o_x <= 0) begin
                o_sector = svpwm_pkg::SEC_6;
            end else begin
                o_sector = svpwm_pkg::SEC_1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/svpwm_duty_cycle_calc_core.sv =====
// top level: space vector pwm duty and sector calculator
`default_nettype none

// Takes one alpha/beta voltage command (signed q1.15) per start transaction and
// returns the three phase compare values and the sector number, marked by a
// one-cycle o_done strobe. The datapath is a five-register pipeline (command,
// products, x/y/z and sector, quotients, result), so a new command may be
// started in every cycle and o_busy stays low; the receiver cannot stall, so
// results must be taken when o_done is high. Configuration writes (index 0:
// timer period in ticks, index 1: period_sqrt3) are always accepted and
// should be made while no command is in flight; other indexes are ignored.
// Phase values wrap to 16 bits and are not saturated.

module svpwm_duty_cycle_calc_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // command channel
    input  wire logic                                 i_start,
    output logic                                      o_busy,
    input  wire svpwm_pkg::t_cmd                      i_cmd,
    // result channel
    output logic                                      o_done,
    output svpwm_pkg::t_result                        o_result,
    // configuration channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [svpwm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [svpwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [svpwm_pkg::PERIOD_W-1:0] r_period_ticks;
    logic [svpwm_pkg::SQRT3_W-1:0]  r_period_sqrt3;

    // stage valids, one per pipeline register
    logic r_v0, r_v1, r_v2, r_v3, r_done;

    // stage 0: captured command
    svpwm_pkg::t_cmd r_cmd;

    // stage 1: scaled products
    logic signed [svpwm_pkg::PROD_W-1:0] r_ua;
    logic signed [svpwm_pkg::PROD_W-1:0] r_ub;
    logic [svpwm_pkg::T_W-1:0]           r_t1;

    // stage 2: x, y, z and sector
    logic signed [svpwm_pkg::PROD_W-1:0] r_x;
    logic signed [svpwm_pkg::PROD_W-1:0] r_y;
    logic signed [svpwm_pkg::PROD_W-1:0] r_z;
    logic [svpwm_pkg::T_W-1:0]           r_t2;
    svpwm_pkg::t_sector                  r_sec2;

    // stage 3: truncated quotients, low 16 bits
    logic [svpwm_pkg::DUTY_W-1:0] r_qa;
    logic [svpwm_pkg::DUTY_W-1:0] r_qx;
    logic [svpwm_pkg::DUTY_W-1:0] r_qy;
    logic [svpwm_pkg::DUTY_W-1:0] r_qz;
    svpwm_pkg::t_sector           r_sec3;

    // result register
    svpwm_pkg::t_result r_result;

    logic                                accept;
    logic [svpwm_pkg::T_W-1:0]           t_scale;
    logic signed [svpwm_pkg::PROD_W-1:0] n_ua;
    logic signed [svpwm_pkg::PROD_W-1:0] n_ub;
    logic signed [svpwm_pkg::PROD_W-1:0] xyz_x;
    logic signed [svpwm_pkg::PROD_W-1:0] xyz_y;
    logic signed [svpwm_pkg::PROD_W-1:0] xyz_z;
    svpwm_pkg::t_sector                  xyz_sec;
    logic signed [svpwm_pkg::NUM_W-1:0]  num;
    logic signed [svpwm_pkg::NUM_W-1:0]  t_ext;
    logic [svpwm_pkg::DUTY_W-1:0]        half_t;
    logic [svpwm_pkg::DUTY_W-1:0]        n_qa;
    svpwm_pkg::t_result                  n_result;

    // pipeline never holds a command off
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ticks <= svpwm_pkg::PERIOD_RST;
            r_period_sqrt3 <= svpwm_pkg::SQRT3_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                svpwm_pkg::CFG_PERIOD_TICKS: begin
                    r_period_ticks <= i_cfg_data[svpwm_pkg::PERIOD_W-1:0];
                end
                svpwm_pkg::CFG_PERIOD_SQRT3: begin
                    r_period_sqrt3 <= i_cfg_data[svpwm_pkg::SQRT3_W-1:0];
                end
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v0   <= accept;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3;
        end
    end

    // stage 0: command register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
    end

    // stage 1: alpha * period_sqrt3 and -(beta * t), one multiplier each
    always_comb begin
        t_scale = {r_period_ticks, 2'b00};
        n_ua    = svpwm_pkg::PROD_W'(r_cmd.v_alpha * $signed({1'b0, r_period_sqrt3}));
        n_ub    = -(svpwm_pkg::PROD_W'(r_cmd.v_beta * $signed({2'b00, t_scale})));
    end

    always_ff @(posedge i_clk) begin
        if (r_v0) begin
            r_ua <= n_ua;
            r_ub <= n_ub;
            r_t1 <= t_scale;
        end
    end

    // stage 2: x, y, z and sector
    svpwm_xyz u_xyz (
        .i_ua     (r_ua),
        .i_ub     (r_ub),
        .o_x      (xyz_x),
        .o_y      (xyz_y),
        .o_z      (xyz_z),
        .o_sector (xyz_sec)
    );

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_x    <= xyz_x;
            r_y    <= xyz_y;
            r_z    <= xyz_z;
            r_t2   <= r_t1;
            r_sec2 <= xyz_sec;
        end
    end

    // stage 3: sector numerator, halved and scaled down by 131072 in one shift
    always_comb begin
        t_ext  = $signed({{(svpwm_pkg::NUM_W-svpwm_pkg::T_W){1'b0}}, r_t2});
        half_t = svpwm_pkg::DUTY_W'(r_t2 >> 3);
        case (r_sec2)
            svpwm_pkg::SEC_1, svpwm_pkg::SEC_4: begin
                num = t_ext + svpwm_pkg::NUM_W'(r_x) - svpwm_pkg::NUM_W'(r_z);
            end
            svpwm_pkg::SEC_2, svpwm_pkg::SEC_5: begin
                num = t_ext + svpwm_pkg::NUM_W'(r_y) - svpwm_pkg::NUM_W'(r_z);
            end
            default: begin
                // sectors 3 and 6
                num = t_ext - svpwm_pkg::NUM_W'(r_x) + svpwm_pkg::NUM_W'(r_y);
            end
        endcase
        n_qa = half_t + svpwm_pkg::quot_trunc(num, svpwm_pkg::NUM_DIV_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_qa   <= n_qa;
            r_qx   <= svpwm_pkg::quot_trunc(svpwm_pkg::NUM_W'(r_x), svpwm_pkg::DIV_SHIFT);
            r_qy   <= svpwm_pkg::quot_trunc(svpwm_pkg::NUM_W'(r_y), svpwm_pkg::DIV_SHIFT);
            r_qz   <= svpwm_pkg::quot_trunc(svpwm_pkg::NUM_W'(r_z), svpwm_pkg::DIV_SHIFT);
            r_sec3 <= r_sec2;
        end
    end

    // stage 4: phase times, modulo 16 bits
    always_comb begin
        n_result.duty_a = r_qa;
        n_result.sector = r_sec3;
        case (r_sec3)
            svpwm_pkg::SEC_1, svpwm_pkg::SEC_4: begin
                n_result.duty_b = r_qa + r_qz;
                n_result.duty_c = r_qa + r_qz - r_qx;
            end
            svpwm_pkg::SEC_2, svpwm_pkg::SEC_5: begin
                n_result.duty_b = r_qa + r_qz;
                n_result.duty_c = r_qa - r_qy;
            end
            default: begin
                // sectors 3 and 6
                n_result.duty_c = r_qa - r_qy;
                n_result.duty_b = r_qa - r_qy + r_qx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_v3) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/svpwm_checker.sv =====
// port-level checker for the duty calculator, bound to the top level
`default_nettype none

module svpwm_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_start,
    input wire logic                o_busy,
    input wire logic                o_done,
    input wire svpwm_pkg::t_result  o_result
);

    // every accepted transaction yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##5 o_done)
        else $error("result missing after accepted transaction");

    // no result without a matching transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##5 !o_done)
        else $error("result strobe without a transaction");

    // reported sector is always one of the six
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.sector >= svpwm_pkg::SEC_1 &&
                    o_result.sector <= svpwm_pkg::SEC_6))
        else $error("sector out of range");

    // the result strobe is low in the cycle after reset is sampled asserted
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

endmodule

bind svpwm_duty_cycle_calc_core svpwm_checker u_svpwm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

// ===== test/svpwm_checker.sv =====
// checker for the space vector duty calculator: predicts and compares each result
module svpwm_scoreboard (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic                             i_busy,
    input  wire svpwm_pkg::t_cmd                  i_cmd,
    input  wire logic                             i_done,
    input  wire svpwm_pkg::t_result               i_result,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic [svpwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [svpwm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked
);

    logic [svpwm_pkg::PERIOD_W-1:0] period_q = svpwm_pkg::PERIOD_RST;
    logic [svpwm_pkg::SQRT3_W-1:0]  sqrt3_q  = svpwm_pkg::SQRT3_RST;
    svpwm_pkg::t_result             duty_expected_q[$];
    int                             fails    = 0;
    int                             checked  = 0;

    // phase times and sector for one command under the current registers
    function automatic svpwm_pkg::t_result predict_duty(
        input svpwm_pkg::t_cmd                cmd,
        input logic [svpwm_pkg::PERIOD_W-1:0] period,
        input logic [svpwm_pkg::SQRT3_W-1:0]  sqrt3
    );
        longint             t, ua, ub, x, y, z, ta, tb, tc;
        svpwm_pkg::t_sector sec;
        svpwm_pkg::t_result r;
        t  = longint'(period) * 4;
        ua = longint'($signed(cmd.v_alpha)) * longint'(sqrt3);
        ub = -(longint'($signed(cmd.v_beta)) * t);
        x  = ub;
        y  = (ub + ua) / 2;
        z  = (ub - ua) / 2;
        if (y < 0) begin
            if (z < 0)
                sec = svpwm_pkg::SEC_5;
            else
                sec = (x <= 0) ? svpwm_pkg::SEC_4 : svpwm_pkg::SEC_3;
        end else begin
            if (z >= 0)
                sec = svpwm_pkg::SEC_2;
            else
                sec = (x <= 0) ? svpwm_pkg::SEC_6 : svpwm_pkg::SEC_1;
        end
        if (sec == svpwm_pkg::SEC_1 || sec == svpwm_pkg::SEC_4) begin
            ta = t / 8 + (((t + x) - z) / 2) / 131072;
            tb = ta + z / 131072;
            tc = tb - x / 131072;
        end else if (sec == svpwm_pkg::SEC_2 || sec == svpwm_pkg::SEC_5) begin
            ta = t / 8 + (((t + y) - z) / 2) / 131072;
            tb = ta + z / 131072;
            tc = ta - y / 131072;
        end else begin
            ta = t / 8 + (((t - x) + y) / 2) / 131072;
            tc = ta - y / 131072;
            tb = tc + x / 131072;
        end
        r.duty_a = ta[svpwm_pkg::DUTY_W-1:0];
        r.duty_b = tb[svpwm_pkg::DUTY_W-1:0];
        r.duty_c = tc[svpwm_pkg::DUTY_W-1:0];
        r.sector = sec;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        svpwm_pkg::t_result want;
        if (!i_rst_n) begin
            period_q = svpwm_pkg::PERIOD_RST;
            sqrt3_q  = svpwm_pkg::SQRT3_RST;
            duty_expected_q.delete();
        end else begin
            if (i_done) begin
                if (duty_expected_q.size() == 0) begin
                    $error("result with no command outstanding: %p", i_result);
                    fails++;
                end else begin
                    want = duty_expected_q.pop_front();
                    check_field("duty_a", want.duty_a, i_result.duty_a);
                    check_field("duty_b", want.duty_b, i_result.duty_b);
                    check_field("duty_c", want.duty_c, i_result.duty_c);
                    check_field("sector", want.sector, i_result.sector);
                    checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    svpwm_pkg::CFG_PERIOD_TICKS:
                        period_q = i_cfg_data[svpwm_pkg::PERIOD_W-1:0];
                    svpwm_pkg::CFG_PERIOD_SQRT3:
                        sqrt3_q  = i_cfg_data[svpwm_pkg::SQRT3_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                duty_expected_q.push_back(predict_duty(i_cmd, period_q, sqrt3_q));
        end
        o_fail_count <= fails;
        o_pending    <= duty_expected_q.size();
        o_checked    <= checked;
    end

endmodule

// ===== test/tb_svpwm_duty_cycle_calc_core.sv =====
// testbench top: stimulus, register settings and verdict for the duty calculator
module tb_svpwm_duty_cycle_calc_core;

    // pipeline depth given for the block, used for settling pauses
    localparam int LATENCY     = 5;
    // watchdog bound, generous against the slowest correct run
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 70;
    localparam int MAX_GAP     = 40;
    // an index past the register list, written to show it is ignored
    localparam logic [svpwm_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO =
        svpwm_pkg::CFG_IDX_W'(svpwm_pkg::CFG_PERIOD_SQRT3 + 1);
    localparam logic [svpwm_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = '1;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_start     = 1'b0;
    svpwm_pkg::t_cmd                  i_cmd       = '0;
    logic                             i_cfg_valid = 1'b0;
    logic [svpwm_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [svpwm_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                             o_busy;
    logic                             o_done;
    svpwm_pkg::t_result               o_result;
    logic                             o_cfg_ready;

    int fail_count;
    int pending;
    int checked;
    int cycle_count   = 0;
    int commands_sent = 0;
    int settings_made = 0;

    always #5 i_clk = ~i_clk;

    svpwm_duty_cycle_calc_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // watches all three channels, predicts every result and counts mismatches
    svpwm_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // axis value biased towards the rails and tiny magnitudes near the sector edges
    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // one command transaction; start stays high straight into the next one
    // when no idle gap is drawn, so it is never lowered and raised in one step
    task automatic send_cmd(input logic signed [15:0] alpha, input logic signed [15:0] beta,
                            input int idle_pct);
        int gap;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < MAX_GAP)
            gap++;
        i_start       <= 1'b1;
        i_cmd.v_alpha <= alpha;
        i_cmd.v_beta  <= beta;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        commands_sent++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // lower start and hold off until every outstanding result has come back
    task automatic drain();
        i_start <= 1'b0;
        // checker count is registered, so step the clock before looking
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [svpwm_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [svpwm_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // registers are only touched once the pipeline is empty and settled
    task automatic set_config(input logic [svpwm_pkg::CFG_DATA_W-1:0] period,
                              input logic [svpwm_pkg::CFG_DATA_W-1:0] sqrt3);
        drain();
        repeat (LATENCY) @(posedge i_clk);
        if ($urandom_range(1)) begin
            write_cfg(svpwm_pkg::CFG_PERIOD_TICKS, period);
            write_cfg(svpwm_pkg::CFG_PERIOD_SQRT3, sqrt3);
        end else begin
            write_cfg(svpwm_pkg::CFG_PERIOD_SQRT3, sqrt3);
            write_cfg(svpwm_pkg::CFG_PERIOD_TICKS, period);
        end
        settings_made++;
    endtask

    // run watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int idle_pct;
        int burst_left;
        // synchronous reset held, then released
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset registers: origin, rails, sector edges and
        // one point well inside each sector, back to back with no idling between them
        send_cmd(16'sd0, 16'sd0, 0);
        send_cmd(16'sd1, 16'sd0, 0);
        send_cmd(-16'sd1, 16'sd0, 0);
        send_cmd(16'sd0, 16'sd1, 0);
        send_cmd(16'sd0, -16'sd1, 0);
        send_cmd(16'sh7fff, 16'sd0, 0);
        send_cmd(16'sh8000, 16'sd0, 0);
        send_cmd(16'sd0, 16'sh7fff, 0);
        send_cmd(16'sd0, 16'sh8000, 0);
        send_cmd(16'sh7fff, 16'sh7fff, 0);
        send_cmd(16'sh8000, 16'sh8000, 0);
        send_cmd(16'sh7fff, 16'sh8000, 0);
        send_cmd(16'sh8000, 16'sh7fff, 0);
        send_cmd(16'sd20000, -16'sd1000, 0);
        send_cmd(16'sd1000, -16'sd20000, 0);
        send_cmd(-16'sd20000, -16'sd1000, 0);
        send_cmd(-16'sd20000, 16'sd1000, 0);
        send_cmd(16'sd1000, 16'sd20000, 0);
        send_cmd(16'sd20000, 16'sd1000, 7);

        // random phases, each under its own register setting and one of three idle modes
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_config(16'd9459, 16'hffff);
                1: set_config(16'd1, 16'd1);
                // zero registers are used as written
                2: set_config(16'd0, 16'd0);
                // all ones, upper period bits fall away
                3: set_config(16'hffff, 16'hffff);
                4: set_config(16'($urandom), 16'($urandom));
                5: set_config(16'($urandom_range(9459, 1)), 16'($urandom_range(65535, 1)));
                default: begin
                    set_config(16'(svpwm_pkg::PERIOD_RST), 16'(svpwm_pkg::SQRT3_RST));
                    // writes past the register list must be ignored
                    write_cfg(CFG_IDX_UNUSED_LO, 16'($urandom));
                    write_cfg(CFG_IDX_UNUSED_HI, 16'($urandom));
                end
            endcase
            case (ph % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 53;
                default: idle_pct = 7;
            endcase
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // occasional stretch with no idling inside an idling phase
                if (burst_left == 0 && $urandom_range(15) == 0)
                    burst_left = 8;
                // sender holds off mid-phase until the pipeline is empty
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    drain();
                send_cmd(rand_axis(), rand_axis(), (burst_left > 0) ? 0 : idle_pct);
                if (burst_left > 0)
                    burst_left--;
            end
        end

        // wind down: everything back, then a pause for strays
        drain();
        repeat (4 * LATENCY) @(posedge i_clk);

        $display("run covered %0d commands and %0d checked results", commands_sent, checked);
        $display("over %0d register settings with full-rate, 53%% and 7%% idle sending",
                 settings_made);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/svpwm_pkg.sv
rtl/svpwm_xyz.sv
rtl/svpwm_duty_cycle_calc_core.sv
rtl/svpwm_checker.sv
test/svpwm_checker.sv
test/tb_svpwm_duty_cycle_calc_core.sv
